>>> design/abl_pkg.sv
// Shared constants and types for the audio block level meter.
package abl_pkg;

  localparam int unsigned MaxBlockSamples = 256;
  localparam int unsigned DbFloorQ8       = 25600;
  localparam int unsigned KDbPerLog2Q16   = 394566;
  localparam int unsigned RmsFloorQ31     = 21474;
  localparam int unsigned SmoothOne       = 65536;

  // Fill status of a small queue.
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

>>> design/abl_front.sv
// Per-sample accumulation of sum of squares, peak, clip and sample count.
module abl_front #(
  parameter int unsigned MAX_BLOCK_SAMPLES = abl_pkg::MaxBlockSamples
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          accept_i,
  input  logic signed [15:0]                            sample_i,
  input  logic                                          last_sample_i,
  output logic                                          blk_push_o,
  output logic [30+$clog2(MAX_BLOCK_SAMPLES+1)-1:0]     blk_sum_o,
  output logic [$clog2(MAX_BLOCK_SAMPLES+1)-1:0]        blk_cnt_o,
  output logic [14:0]                                   blk_peak_o,
  output logic                                          blk_clip_o
);
  localparam int unsigned CW = $clog2(MAX_BLOCK_SAMPLES + 1);
  localparam int unsigned SW = 30 + CW;

  logic [SW-1:0] sum_q, sum_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [14:0]   peak_q, peak_d;
  logic          clip_q, clip_d;
  logic [15:0]   abs_val;
  logic [14:0]   mag;
  logic [31:0]   square;
  logic          room;

  always_comb begin
    abs_val = sample_i[15] ? 16'(-sample_i) : 16'(sample_i);
    mag     = (sample_i == -16'sd32768) ? 15'd32767 : abs_val[14:0];
    square  = abs_val * abs_val;
    room    = cnt_q < CW'(MAX_BLOCK_SAMPLES);
    sum_d   = sum_q;
    cnt_d   = cnt_q;
    peak_d  = peak_q;
    clip_d  = clip_q;
    if (room) begin
      sum_d  = sum_q + SW'(square);
      cnt_d  = cnt_q + CW'(1);
      peak_d = (mag > peak_q) ? mag : peak_q;
      clip_d = clip_q | (sample_i == 16'sd32767) | (sample_i == -16'sd32768);
    end
  end

  assign blk_push_o = accept_i & last_sample_i;
  assign blk_sum_o  = sum_d;
  assign blk_cnt_o  = cnt_d;
  assign blk_peak_o = peak_d;
  assign blk_clip_o = clip_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      cnt_q  <= '0;
      peak_q <= '0;
      clip_q <= 1'b0;
    end else if (accept_i) begin
      if (last_sample_i) begin
        sum_q  <= '0;
        cnt_q  <= '0;
        peak_q <= '0;
        clip_q <= 1'b0;
      end else begin
        sum_q  <= sum_d;
        cnt_q  <= cnt_d;
        peak_q <= peak_d;
        clip_q <= clip_d;
      end
    end
  end

endmodule

>>> design/abl_fifo.sv
// Two-entry queue of block summaries between front and back.
module abl_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output abl_pkg::qstat_t  stat_o
);
  logic [WIDTH-1:0] mem_q [2];
  logic             wr_q, rd_q;
  logic [1:0]       fill_q;

  assign stat_o.full  = fill_q == 2'd2;
  assign stat_o.empty = fill_q == 2'd0;
  assign rdata_o      = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= 1'b0;
      rd_q   <= 1'b0;
      fill_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      fill_q <= fill_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

>>> design/abl_back.sv
// Block-end sequencer: divide, square root, smoothing and dB conversion.
module abl_back #(
  parameter int unsigned MAX_BLOCK_SAMPLES = abl_pkg::MaxBlockSamples
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic [16:0]                               smoothing_i,
  input  logic                                      blk_valid_i,
  input  logic [30+$clog2(MAX_BLOCK_SAMPLES+1)-1:0] blk_sum_i,
  input  logic [$clog2(MAX_BLOCK_SAMPLES+1)-1:0]    blk_cnt_i,
  input  logic [14:0]                               blk_peak_i,
  input  logic                                      blk_clip_i,
  output logic                                      blk_pop_o,
  output logic                                      res_valid_o,
  input  logic                                      res_pop_i,
  output logic signed [15:0]                        rms_db_o,
  output logic signed [15:0]                        peak_db_o,
  output logic                                      clip_o
);
  localparam int unsigned CW  = $clog2(MAX_BLOCK_SAMPLES + 1);
  localparam int unsigned SW  = 30 + CW;
  localparam int unsigned STW = $clog2(SW);

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_SQRT, S_MULA, S_MULB, S_SMOOTH,
    S_LOGSTART, S_NORM, S_SQ, S_MULK, S_RND, S_FIN
  } state_e;

  state_e       state_q;
  logic [SW-1:0]  n_q;
  logic [CW-1:0]  r_q, d_q;
  logic [STW-1:0] step_q;
  logic [30:0]  x_q, res_q, bit_q;
  logic [14:0]  peak_q;
  logic         clip_q;
  logic [31:0]  smooth_q;
  logic [48:0]  p1_q;
  logic [32:0]  p2_q;
  logic         which_q;
  logic [31:0]  v_q;
  logic [4:0]   p_q;
  logic [30:0]  y_q;
  logic [15:0]  frac_q;
  logic [40:0]  mk_q;
  logic [15:0]  db_q, rmsdb_q;
  logic         out_valid_q;
  logic [15:0]  out_rms_q, out_peak_q;
  logic         out_clip_q;

  // combinational helpers
  logic [CW:0]   div_rem;
  logic          div_ge;
  logic [SW-1:0] n_next;
  logic [31:0]   sq_sum;
  logic [16:0]   s_eff;
  logic [49:0]   acc;
  logic [31:0]   lv;
  logic          lfloor;
  logic [61:0]   ysq;
  logic [20:0]   full_l, l_val, m_val;
  logic [40:0]   mag_r;
  logic [15:0]   mag_c;
  logic          out_free;

  always_comb begin
    div_rem = {r_q, n_q[SW-1]};
    div_ge  = div_rem >= {1'b0, d_q};
    n_next  = {n_q[SW-2:0], div_ge};
    sq_sum  = {1'b0, res_q} + {1'b0, bit_q};
    s_eff   = (smoothing_i > 17'(abl_pkg::SmoothOne)) ? 17'(abl_pkg::SmoothOne)
                                                      : smoothing_i;
    acc     = 50'(p1_q) + {1'b0, p2_q, 16'b0};
    lv      = which_q ? {17'b0, peak_q} : smooth_q;
    lfloor  = which_q ? (peak_q == '0) : (smooth_q <= 32'(abl_pkg::RmsFloorQ31));
    ysq     = y_q * y_q;
    full_l  = which_q ? {5'd15, 16'b0} : {5'd31, 16'b0};
    l_val   = {p_q, frac_q};
    m_val   = (l_val > full_l) ? '0 : full_l - l_val;
    mag_r   = (mk_q + 41'(1 << 23)) >> 24;
    mag_c   = (mag_r > 41'(abl_pkg::DbFloorQ8)) ? 16'(abl_pkg::DbFloorQ8) : mag_r[15:0];
    out_free = !out_valid_q || res_pop_i;
  end

  assign blk_pop_o   = (state_q == S_IDLE) && blk_valid_i;
  assign res_valid_o = out_valid_q;
  assign rms_db_o    = out_rms_q;
  assign peak_db_o   = out_peak_q;
  assign clip_o      = out_clip_q;

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        n_q    <= blk_sum_i;
        r_q    <= '0;
        d_q    <= blk_cnt_i;
        peak_q <= blk_peak_i;
        clip_q <= blk_clip_i;
      end
      S_DIV: begin
        r_q <= div_ge ? CW'(div_rem - {1'b0, d_q}) : div_rem[CW-1:0];
        n_q <= n_next;
        x_q <= n_next[30:0];
        res_q <= '0;
        bit_q <= 31'(1) << 30;
      end
      S_SQRT: begin
        if ({1'b0, x_q} >= sq_sum) begin
          x_q   <= 31'({1'b0, x_q} - sq_sum);
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      S_MULA:   p1_q <= smooth_q * s_eff;
      S_MULB:   p2_q <= res_q[15:0] * (17'(abl_pkg::SmoothOne) - s_eff);
      S_LOGSTART: begin
        v_q    <= lv;
        p_q    <= 5'd31;
        frac_q <= '0;
        db_q   <= 16'(-(17'(abl_pkg::DbFloorQ8)));
      end
      S_NORM: begin
        if (v_q[31]) begin
          y_q <= v_q[31:1];
        end else begin
          v_q <= v_q << 1;
          p_q <= p_q - 5'd1;
        end
      end
      S_SQ: begin
        if (ysq[61]) begin
          y_q    <= ysq[61:31];
          frac_q <= {frac_q[14:0], 1'b1};
        end else begin
          y_q    <= ysq[60:30];
          frac_q <= {frac_q[14:0], 1'b0};
        end
      end
      S_MULK:   mk_q <= m_val * 20'(abl_pkg::KDbPerLog2Q16);
      S_RND:    db_q <= 16'(-mag_c);
      S_FIN: begin
        if (!which_q) begin
          rmsdb_q <= db_q;
        end
      end
      default: ;
    endcase
  end

  // control: state, step counter, smoothed RMS and the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      which_q     <= 1'b0;
      smooth_q    <= '0;
      out_valid_q <= 1'b0;
      out_rms_q   <= '0;
      out_peak_q  <= '0;
      out_clip_q  <= 1'b0;
    end else begin
      // the final peak step loads the result register itself
      if (res_pop_i && !(state_q == S_FIN && which_q)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          step_q <= '0;
          if (blk_valid_i) begin
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          step_q <= step_q + STW'(1);
          if (step_q == STW'(SW - 1)) begin
            state_q <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (bit_q[0]) begin
            state_q <= S_MULA;
          end
        end
        S_MULA:   state_q <= S_MULB;
        S_MULB:   state_q <= S_SMOOTH;
        S_SMOOTH: begin
          smooth_q <= acc[47:16];
          which_q  <= 1'b0;
          state_q  <= S_LOGSTART;
        end
        S_LOGSTART: begin
          step_q  <= '0;
          state_q <= lfloor ? S_FIN : S_NORM;
        end
        S_NORM: begin
          if (v_q[31]) begin
            state_q <= S_SQ;
          end
        end
        S_SQ: begin
          step_q <= step_q + STW'(1);
          if (step_q == STW'(15)) begin
            state_q <= S_MULK;
          end
        end
        S_MULK:   state_q <= S_RND;
        S_RND:    state_q <= S_FIN;
        S_FIN: begin
          if (!which_q) begin
            which_q <= 1'b1;
            state_q <= S_LOGSTART;
          end else if (out_free) begin
            out_valid_q <= 1'b1;
            out_rms_q   <= rmsdb_q;
            out_peak_q  <= db_q;
            out_clip_q  <= clip_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

>>> design/audio_block_level_meter.sv
// Top level of the audio block level meter.
// Usage:
//  - Samples enter through a queue-style port: an item is taken on a clock
//    edge with push high and full low. last_sample_i closes a block.
//  - Each sample, up to MAX_BLOCK_SAMPLES per block, is accumulated in the
//    same cycle; a new sample can enter every cycle while the two-entry
//    summary queue has room.
//  - At each block end a summary is queued for the back-end sequencer:
//    queue pop, restoring divide of the 30+clog2(MAX_BLOCK_SAMPLES+1) = 39-bit
//    sum, bit-pair square root, smoothing multiply, then two dB
//    conversions (leading-one search one bit per cycle, 16 squarings of the
//    shared 31x31 multiplier, scale and round).
//  - Results leave through empty/pop: the oldest result is on the ports while
//    empty is low, taken on an edge with pop high. A held result parks the
//    sequencer in its final step; the summary queue takes two more blocks.
//  - full rises while two block summaries wait; sample input then stalls.
//  - Reset clears accumulators, smoothed RMS, queues and smoothing (0).
//  - smoothing_q16 is to be written only when the block is idle (the user's
//    duty, not enforced by the block); values above 65536 act as 65536.
module audio_block_level_meter #(
  parameter int unsigned MAX_BLOCK_SAMPLES = abl_pkg::MaxBlockSamples
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic signed [15:0] sample_i,
  input  logic               last_sample_i,
  output logic               empty,
  input  logic               pop,
  output logic signed [15:0] rms_level_db_o,
  output logic signed [15:0] peak_level_db_o,
  output logic               clipped_o,
  input  logic               smoothing_q16_we_i,
  input  logic [16:0]        smoothing_q16_i
);
  localparam int unsigned CW = $clog2(MAX_BLOCK_SAMPLES + 1);
  localparam int unsigned SW = 30 + CW;
  localparam int unsigned QW = SW + CW + 16;

  logic [16:0]     smoothing_q;
  logic            accept;
  logic            blk_push, blk_pop, res_valid;
  logic [SW-1:0]   f_sum;
  logic [CW-1:0]   f_cnt;
  logic [14:0]     f_peak;
  logic            f_clip;
  logic [QW-1:0]   q_rdata;
  abl_pkg::qstat_t q_stat;

  assign full   = q_stat.full;
  assign accept = push & ~q_stat.full;
  assign empty  = ~res_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smoothing_q <= '0;
    end else if (smoothing_q16_we_i) begin
      smoothing_q <= smoothing_q16_i;
    end
  end

  abl_front #(.MAX_BLOCK_SAMPLES(MAX_BLOCK_SAMPLES)) u_front (
    .clk_i, .rst_ni,
    .accept_i      (accept),
    .sample_i,
    .last_sample_i,
    .blk_push_o    (blk_push),
    .blk_sum_o     (f_sum),
    .blk_cnt_o     (f_cnt),
    .blk_peak_o    (f_peak),
    .blk_clip_o    (f_clip)
  );

  abl_fifo #(.WIDTH(QW)) u_fifo (
    .clk_i, .rst_ni,
    .push_i  (blk_push),
    .wdata_i ({f_sum, f_cnt, f_peak, f_clip}),
    .pop_i   (blk_pop),
    .rdata_o (q_rdata),
    .stat_o  (q_stat)
  );

  abl_back #(.MAX_BLOCK_SAMPLES(MAX_BLOCK_SAMPLES)) u_back (
    .clk_i, .rst_ni,
    .smoothing_i (smoothing_q),
    .blk_valid_i (~q_stat.empty),
    .blk_sum_i   (q_rdata[QW-1 -: SW]),
    .blk_cnt_i   (q_rdata[CW+15:16]),
    .blk_peak_i  (q_rdata[15:1]),
    .blk_clip_i  (q_rdata[0]),
    .blk_pop_o   (blk_pop),
    .res_valid_o (res_valid),
    .res_pop_i   (pop),
    .rms_db_o    (rms_level_db_o),
    .peak_db_o   (peak_level_db_o),
    .clip_o      (clipped_o)
  );

  // A block end must never be pushed into a full summary queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(blk_push && q_stat.full))
    else $error("summary queue overflow");

  // Levels always lie between the floor and 0 dB.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (rms_level_db_o <= 16'sd0 && rms_level_db_o >= -16'sd25600))
    else $error("rms level out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (peak_level_db_o <= 16'sd0 && peak_level_db_o >= -16'sd25600))
    else $error("peak level out of range");

  // A clipped block has a full-scale peak, which rounds to 0 dB.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && clipped_o) |-> peak_level_db_o == 16'sd0)
    else $error("clip without full-scale peak");

endmodule
